// ----- design/dqps_pkg.sv -----
// shared constants and codes for the deque with position search
`timescale 1ns / 1ps

package dqps_pkg;

  localparam int DEPTH    = 1024;
  localparam int ID_WIDTH = 32;

  typedef enum logic [2:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_READ       = 3'd4,
    FN_FIND       = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

endpackage

// ----- design/deque_with_position_search.sv -----
// ring-buffer deque with read at position and linear search over one memory
// result path: push, pop and rejected requests go straight to RESP, a read passes RD_WAIT first,
// and a find that stops at 1-based position p passes SCAN first (one stored entry compared per cycle)
// find cost is set by the single memory read port and grows with the position reached
// a new beat is taken the cycle after the result beat is taken, so requests never overlap
// reset (synchronous) clears head pointer, count and control; memory contents stay undefined
`timescale 1ns / 1ps

module deque_with_position_search #(
  parameter int DEPTH    = dqps_pkg::DEPTH,
  parameter int ID_WIDTH = dqps_pkg::ID_WIDTH,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW      = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          func,
  input  logic [ID_WIDTH-1:0] item_value,
  input  logic [CW-1:0]       position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [ID_WIDTH-1:0] value_out,
  output logic [CW-1:0]       position_out,
  output logic [CW-1:0]       occupancy
);

  localparam logic [AW:0]   DEPTH_S   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  typedef enum logic [1:0] {
    IDLE,
    RD_WAIT,
    SCAN,
    RESP
  } state_t;

  state_t               state;
  logic [AW-1:0]        head;
  logic [CW-1:0]        count;
  logic [AW-1:0]        cmp_k;
  logic [ID_WIDTH-1:0]  key;

  logic [ID_WIDTH-1:0]  mem [DEPTH];
  logic [ID_WIDTH-1:0]  rdata;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;

  logic                 full;
  logic                 empty;
  logic [AW-1:0]        head_inc;
  logic [AW-1:0]        head_dec;
  logic [AW-1:0]        pos_m1;
  logic [CW-1:0]        cmp_pos;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + b;
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign head_inc = (head == LAST_SLOT) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? LAST_SLOT : head - AW'(1);
  assign pos_m1   = AW'(position - CW'(1));
  assign cmp_pos  = CW'(cmp_k) + CW'(1);
  assign in_ready = (state == IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = ring_add(head, {1'b0, count[AW-1:0]});
    if (state == IDLE && in_valid && !full) begin
      case (dqps_pkg::func_t'(func))
        dqps_pkg::FN_PUSH_BACK: begin
          we = 1'b1;
        end
        dqps_pkg::FN_PUSH_FRONT: begin
          we    = 1'b1;
          waddr = head_dec;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (state == SCAN) begin
      raddr = ring_add(head, {1'b0, cmp_k} + (AW + 1)'(1));
    end else if (dqps_pkg::func_t'(func) == dqps_pkg::FN_READ) begin
      raddr = ring_add(head, {1'b0, pos_m1});
    end else begin
      raddr = head;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= item_value;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            key          <= item_value;
            value_out    <= '0;
            position_out <= '0;
            occupancy    <= count;
            status       <= dqps_pkg::ST_OK;
            cmp_k        <= '0;
            state        <= RESP;
            out_valid    <= 1'b1;
            case (dqps_pkg::func_t'(func))
              dqps_pkg::FN_PUSH_BACK, dqps_pkg::FN_PUSH_FRONT: begin
                if (full) begin
                  status <= dqps_pkg::ST_FULL;
                end else begin
                  count     <= count + CW'(1);
                  occupancy <= count + CW'(1);
                  if (dqps_pkg::func_t'(func) == dqps_pkg::FN_PUSH_FRONT) begin
                    head <= head_dec;
                  end
                end
              end
              dqps_pkg::FN_POP_FRONT, dqps_pkg::FN_POP_BACK: begin
                if (empty) begin
                  status <= dqps_pkg::ST_EMPTY;
                end else begin
                  count     <= count - CW'(1);
                  occupancy <= count - CW'(1);
                  if (dqps_pkg::func_t'(func) == dqps_pkg::FN_POP_FRONT) begin
                    head <= head_inc;
                  end
                end
              end
              dqps_pkg::FN_READ: begin
                if (empty) begin
                  status <= dqps_pkg::ST_EMPTY;
                end else if (position == '0 || position > count) begin
                  status <= dqps_pkg::ST_RANGE;
                end else begin
                  state     <= RD_WAIT;
                  out_valid <= 1'b0;
                end
              end
              dqps_pkg::FN_FIND: begin
                if (empty) begin
                  status <= dqps_pkg::ST_EMPTY;
                end else begin
                  state     <= SCAN;
                  out_valid <= 1'b0;
                end
              end
              default: begin
                status <= dqps_pkg::ST_OK;
              end
            endcase
          end
        end
        RD_WAIT: begin
          value_out <= rdata;
          status    <= dqps_pkg::ST_OK;
          state     <= RESP;
          out_valid <= 1'b1;
        end
        SCAN: begin
          if (rdata == key) begin
            status       <= dqps_pkg::ST_OK;
            position_out <= cmp_pos;
            state        <= RESP;
            out_valid    <= 1'b1;
          end else if (cmp_pos == count) begin
            status    <= dqps_pkg::ST_NOT_FOUND;
            state     <= RESP;
            out_valid <= 1'b1;
          end else begin
            cmp_k <= cmp_k + AW'(1);
          end
        end
        RESP: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: begin
          state     <= IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule
